// ===== src/s3tc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S3TC decoder package
// Shared beat types, configuration codes and limits of the block decoder.
// ----------------------------------------------------------------------------
package s3tc_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = 13;

  typedef enum logic [1:0] {
    CFG_FORMAT_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] alpha_bits;
    logic [63:0] color_bits;
    logic [9:0]  block_col;
    logic [9:0]  block_row;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } out_item_t;

  // Live configuration seen by the front end, limits already clamped.
  typedef struct packed {
    logic             dxt5;
    logic [DIM_W-1:0] wlim;
    logic [DIM_W-1:0] hlim;
  } cfg_t;

  // One decoded block waiting for pixel emission. Channel 0 is red.
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic [7:0][7:0]      apal;
    logic [15:0][1:0]     cidx;
    logic [15:0][2:0]     acode;
    logic [9:0]           col;
    logic [9:0]           row;
    logic [2:0]           ncols;
    logic [2:0]           nrows;
  } blk_t;

endpackage
`default_nettype wire

// ===== src/s3tc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S3TC front end
// Accepts blocks, expands endpoints, sizes the visible window and builds the
// color and alpha palettes across the stage A register and stage B.
// ----------------------------------------------------------------------------
module s3tc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  s3tc_pkg::cfg_t       cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  s3tc_pkg::in_item_t   in_data_i,
  output logic                 push_valid_o,
  input  wire                  push_ready_i,
  output s3tc_pkg::blk_t       push_blk_o
);

  typedef struct packed {
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic             four;
    logic             dxt5;
    logic             agt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [5:0][10:0] anum;
    logic [15:0][1:0] cidx;
    logic [15:0][2:0] acode;
    logic [9:0]       col;
    logic [9:0]       row;
    logic [2:0]       ncols;
    logic [2:0]       nrows;
  } stg_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] t;
    logic [13:0] s;
    t = 13'(v) * 13'd255 + 13'd16;
    s = 14'(t >> 5) + 14'(t);
    return 8'(s >> 5);
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] t;
    logic [14:0] s;
    t = 14'(v) * 14'd255 + 14'd32;
    s = 15'(t >> 6) + 15'(t);
    return 8'(s >> 6);
  endfunction

  // Division by small constants via a reciprocal, exact for every palette sum fed in.
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd87382;
    return p[25:18];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd52429;
    return p[25:18];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd37450;
    return p[25:18];
  endfunction

  function automatic logic [2:0] span(input logic [12:0] lim, input logic [11:0] base);
    logic [12:0] diff;
    diff = lim - {1'b0, base};
    if (lim <= {1'b0, base}) begin
      return 3'd0;
    end else if (diff >= 13'd4) begin
      return 3'd4;
    end else begin
      return diff[2:0];
    end
  endfunction

  stg_t a_d, a_q;
  logic a_valid_q;
  logic a_drop, a_done;
  logic [15:0] c0, c1;

  // Stage A: expand endpoints, weigh alpha endpoints, size the window.
  always_comb begin
    c0 = in_data_i.color_bits[15:0];
    c1 = in_data_i.color_bits[31:16];
    a_d = '0;
    a_d.e0[0] = expand5(c0[15:11]);
    a_d.e0[1] = expand6(c0[10:5]);
    a_d.e0[2] = expand5(c0[4:0]);
    a_d.e1[0] = expand5(c1[15:11]);
    a_d.e1[1] = expand6(c1[10:5]);
    a_d.e1[2] = expand5(c1[4:0]);
    a_d.dxt5  = cfg_i.dxt5;
    a_d.four  = cfg_i.dxt5 || (c0 > c1);
    a_d.a0    = in_data_i.alpha_bits[7:0];
    a_d.a1    = in_data_i.alpha_bits[15:8];
    a_d.agt   = a_d.a0 > a_d.a1;
    for (int k = 0; k < 6; k++) begin
      if (a_d.agt) begin
        a_d.anum[k] = 11'(a_d.a0) * 11'(6 - k) + 11'(a_d.a1) * 11'(k + 1);
      end else if (k < 4) begin
        a_d.anum[k] = 11'(a_d.a0) * 11'(4 - k) + 11'(a_d.a1) * 11'(k + 1);
      end else begin
        a_d.anum[k] = '0;
      end
    end
    a_d.cidx  = in_data_i.color_bits[63:32];
    a_d.acode = in_data_i.alpha_bits[63:16];
    a_d.col   = in_data_i.block_col;
    a_d.row   = in_data_i.block_row;
    a_d.ncols = span(cfg_i.wlim, {in_data_i.block_col, 2'b00});
    a_d.nrows = span(cfg_i.hlim, {in_data_i.block_row, 2'b00});
  end

  // Drop a block with nothing visible; it never reaches the queue.
  assign a_drop       = (a_q.ncols == 3'd0) || (a_q.nrows == 3'd0);
  assign a_done       = a_valid_q && (a_drop || push_ready_i);
  assign in_ready_o   = !a_valid_q || a_done;
  assign push_valid_o = a_valid_q && !a_drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= a_d;
    end
  end

  // Stage B: palette entries, straight into the queue.
  always_comb begin
    push_blk_o       = '0;
    push_blk_o.cidx  = a_q.cidx;
    push_blk_o.acode = a_q.acode;
    push_blk_o.col   = a_q.col;
    push_blk_o.row   = a_q.row;
    push_blk_o.ncols = a_q.ncols;
    push_blk_o.nrows = a_q.nrows;
    for (int k = 0; k < 3; k++) begin
      push_blk_o.pal[0][k] = a_q.e0[k];
      push_blk_o.pal[1][k] = a_q.e1[k];
      if (a_q.four) begin
        push_blk_o.pal[2][k] = div3({a_q.e0[k], 1'b0} + 10'(a_q.e1[k]));
        push_blk_o.pal[3][k] = div3(10'(a_q.e0[k]) + {a_q.e1[k], 1'b0});
      end else begin
        push_blk_o.pal[2][k] = 8'((9'(a_q.e0[k]) + 9'(a_q.e1[k])) >> 1);
        push_blk_o.pal[3][k] = 8'd0;
      end
    end
    push_blk_o.apal[0] = a_q.dxt5 ? a_q.a0 : 8'd255;
    push_blk_o.apal[1] = a_q.dxt5 ? a_q.a1 : 8'd255;
    for (int k = 0; k < 6; k++) begin
      if (!a_q.dxt5) begin
        push_blk_o.apal[k+2] = 8'd255;
      end else if (a_q.agt) begin
        push_blk_o.apal[k+2] = div7(a_q.anum[k]);
      end else if (k < 4) begin
        push_blk_o.apal[k+2] = div5(a_q.anum[k]);
      end else if (k == 4) begin
        push_blk_o.apal[k+2] = 8'd0;
      end else begin
        push_blk_o.apal[k+2] = 8'd255;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/s3tc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S3TC block queue
// Two-entry queue of decoded blocks between front and back end.
// ----------------------------------------------------------------------------
module s3tc_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  s3tc_pkg::blk_t   push_blk_i,
  output logic             head_valid_o,
  input  wire              head_pop_i,
  output s3tc_pkg::blk_t   head_blk_o
);

  s3tc_pkg::blk_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_blk_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = head_pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_blk_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/s3tc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S3TC back end
// Walks the visible window of the head block, one pixel per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module s3tc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  head_valid_i,
  input  s3tc_pkg::blk_t       head_blk_i,
  output logic                 head_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output s3tc_pkg::out_item_t  out_data_o
);

  logic [1:0] c_q, r_q;
  logic       out_valid_q;
  s3tc_pkg::out_item_t out_q, out_d;
  logic       issue, last_col, last_row;
  logic [3:0] p;
  logic [1:0] ci;
  logic [2:0] ac;

  assign issue    = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_col = ({1'b0, c_q} == head_blk_i.ncols - 3'd1);
  assign last_row = ({1'b0, r_q} == head_blk_i.nrows - 3'd1);
  assign head_pop_o = issue && last_col && last_row;

  always_comb begin
    p  = {r_q, c_q};
    ci = head_blk_i.cidx[p];
    ac = head_blk_i.acode[p];
    out_d.pixel_x = {head_blk_i.col, c_q};
    out_d.pixel_y = {head_blk_i.row, r_q};
    out_d.red     = head_blk_i.pal[ci][0];
    out_d.green   = head_blk_i.pal[ci][1];
    out_d.blue    = head_blk_i.pal[ci][2];
    out_d.alpha   = head_blk_i.apal[ac];
    out_d.last    = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q         <= 2'd0;
      r_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance across the row, wrap to the next row, restart per block.
      if (issue) begin
        if (last_col) begin
          c_q <= 2'd0;
          r_q <= last_row ? 2'd0 : r_q + 2'd1;
        end else begin
          c_q <= c_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/s3tc_block_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S3TC block decoder
// Decodes DXT1 / DXT5 4x4 blocks into clipped RGBA pixels, in raster order per block.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Beat
//  in        sink       in_valid/in_ready     one compressed block + position
//  out       source     out_valid/out_ready   one RGBA pixel with x, y, last
//  cfg       sink       cfg_we                one register write, no wait
//
//  The back end emits one pixel per cycle unless the output stalls: an
//  unclipped block gives 16 pixels, a clipped one ncols*nrows, and a fully
//  clipped block is dropped in the front end. The pixel walk of the back
//  end sets the sustained rate. The first pixel passes the stage A register,
//  the queue and the output register. Reset selects DXT1 and a 4096 x 4096
//  image; the queue and output register come up empty. A stalled output
//  holds the walk; the two-entry queue lets the front end accept until full.
//
module s3tc_block_decoder (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [1:0]            cfg_idx_i,
  input  wire [12:0]           cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  s3tc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output s3tc_pkg::out_item_t  out_data_o
);

  logic        format_mode_q;
  logic [12:0] image_width_q;
  logic [12:0] image_height_q;
  s3tc_pkg::cfg_t cfg;

  logic           push_valid, push_ready;
  s3tc_pkg::blk_t push_blk;
  logic           head_valid, head_pop;
  s3tc_pkg::blk_t head_blk;

  // Hold configuration; writes outside the register list drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q  <= 1'b0;
      image_width_q  <= 13'(s3tc_pkg::MAX_DIM);
      image_height_q <= 13'(s3tc_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        s3tc_pkg::CFG_FORMAT_MODE:  format_mode_q  <= cfg_wdata_i[0];
        s3tc_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
        s3tc_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the image size to the largest supported dimension.
  always_comb begin
    cfg.dxt5 = format_mode_q;
    cfg.wlim = (image_width_q > 13'(s3tc_pkg::MAX_DIM)) ?
               13'(s3tc_pkg::MAX_DIM) : image_width_q;
    cfg.hlim = (image_height_q > 13'(s3tc_pkg::MAX_DIM)) ?
               13'(s3tc_pkg::MAX_DIM) : image_height_q;
  end

  s3tc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_blk_o   (push_blk)
  );

  s3tc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_blk_i   (push_blk),
    .head_valid_o (head_valid),
    .head_pop_i   (head_pop),
    .head_blk_o   (head_blk)
  );

  s3tc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_blk_i   (head_blk),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // No pixel outside the configured image leaves the block.
  a_clip_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.pixel_x} < cfg.wlim))
    else $error("pixel column beyond image width");

  a_clip_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_data_o.pixel_y} < cfg.hlim))
    else $error("pixel row beyond image height");

  // Only blocks with a visible window enter the queue.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready) |-> (push_blk.ncols != 3'd0 && push_blk.nrows != 3'd0))
    else $error("fully clipped block queued");

  // The back end retires only a block that is present.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3TC block decoder testbench
// Feeds compressed DXT1 / DXT5 blocks through the decoder under a range of
// formats and image sizes. Accepted blocks are decoded here in software, or
// given a typed-in expectation, and every output beat is checked in order.
// Both handshakes idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import s3tc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Lets zero-pixel blocks clear the stage A register of the front end
  // before the setup changes, with room to spare.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RAND_PHASES   = 7;
  localparam int unsigned PHASE_BLOCKS  = 28;
  localparam int unsigned DIR_ROWS      = 24;
  localparam int unsigned MAX_REPORTS   = 10;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [1:0]  CFG_IDX_SPARE   = 2'd3;
  // Alpha codes with fixed meaning when alpha0 <= alpha1.
  localparam int unsigned ALPHA_CODE_ZERO = 6;
  localparam int unsigned ALPHA_CODE_FULL = 7;

  typedef struct packed {
    logic        dxt5;
    logic [12:0] width;
    logic [12:0] height;
  } setup_t;

  // How a directed row is checked: by the decoder below, by one typed-in
  // colour on all sixteen pixels, or by expecting no pixels at all.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_FLAT,
    CHK_EMPTY
  } row_chk_e;

  typedef struct packed {
    setup_t      setup;
    row_chk_e    chk;
    logic [31:0] rgba;
    in_item_t    blk;
  } block_row_t;

  localparam setup_t SET_DXT1_FULL = '{1'b0, 13'd4096, 13'd4096};
  localparam setup_t SET_DXT5_FULL = '{1'b1, 13'd4096, 13'd4096};
  localparam setup_t SET_DXT1_6X5  = '{1'b0, 13'd6, 13'd5};
  localparam setup_t SET_DXT5_1X1  = '{1'b1, 13'd1, 13'd1};
  localparam setup_t SET_NO_WIDTH  = '{1'b0, 13'd0, 13'd4096};
  localparam setup_t SET_NO_HEIGHT = '{1'b0, 13'd4096, 13'd0};
  localparam setup_t SET_DXT5_MAX  = '{1'b1, 13'd8191, 13'd8191};
  localparam setup_t SET_DXT1_4095 = '{1'b0, 13'd4095, 13'd4095};

  localparam logic [63:0] ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
  // Alpha codes 0..7 twice, with alpha0 > alpha1 and alpha0 <= alpha1.
  localparam logic [63:0] ALPHA_DESC = 64'hFAC6_88FA_C688_10F0;
  localparam logic [63:0] ALPHA_ASC  = 64'hFAC6_88FA_C688_C020;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = 2'd0;
  logic [12:0] cfg_wdata = 13'd0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  setup_t      cur_setup = SET_DXT1_FULL;
  out_item_t   pending_pixels [$];
  out_item_t   want;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt  = 0;
  bit          quiet     = 1'b0;
  bit          hold_go   = 1'b0;
  bit          hold_done = 1'b0;
  block_row_t  block_tab [DIR_ROWS];

  s3tc_block_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // Append one expected pixel at the tail of the pending list.
  function automatic void queue_pixel(input out_item_t pix);
    pending_pixels = {pending_pixels, pix};
  endfunction

  // RGB565 channel widening with the format's rounding.
  function automatic int unsigned widen(input int unsigned v, input int unsigned n);
    int unsigned t;
    t = v * 255 + (1 << (n - 1));
    return ((t >> n) + t) >> n;
  endfunction

  function automatic logic [7:0] alpha_level(input int unsigned a0, input int unsigned a1,
                                             input int unsigned code);
    if (code == 0) return 8'(a0);
    if (code == 1) return 8'(a1);
    if (a0 > a1) return 8'(((8 - code) * a0 + (code - 1) * a1) / 7);
    if (code == ALPHA_CODE_ZERO) return 8'd0;
    if (code == ALPHA_CODE_FULL) return 8'd255;
    return 8'(((6 - code) * a0 + (code - 1) * a1) / 5);
  endfunction

  // Decode one block under the current setup and queue its visible pixels.
  function automatic void decode_block(input in_item_t blk);
    int unsigned c0, c1, a0, a1, wlim, hlim, px, py, ci;
    int unsigned e0 [3];
    int unsigned e1 [3];
    int unsigned pal [4][3];
    bit          four;
    bit          have_held;
    out_item_t   held;
    c0 = blk.color_bits[15:0];
    c1 = blk.color_bits[31:16];
    a0 = blk.alpha_bits[7:0];
    a1 = blk.alpha_bits[15:8];
    wlim = (cur_setup.width > MAX_DIM) ? MAX_DIM : cur_setup.width;
    hlim = (cur_setup.height > MAX_DIM) ? MAX_DIM : cur_setup.height;
    e0[0] = widen(blk.color_bits[15:11], 5);
    e0[1] = widen(blk.color_bits[10:5], 6);
    e0[2] = widen(blk.color_bits[4:0], 5);
    e1[0] = widen(blk.color_bits[31:27], 5);
    e1[1] = widen(blk.color_bits[26:21], 6);
    e1[2] = widen(blk.color_bits[20:16], 5);
    four = cur_setup.dxt5 || (c0 > c1);
    for (int k = 0; k < 3; k++) begin
      pal[0][k] = e0[k];
      pal[1][k] = e1[k];
      pal[2][k] = four ? (2 * e0[k] + e1[k]) / 3 : (e0[k] + e1[k]) / 2;
      pal[3][k] = four ? (e0[k] + 2 * e1[k]) / 3 : 0;
    end
    // Hold each pixel back one step so the final one can take the last flag.
    have_held = 1'b0;
    held = '0;
    for (int p = 0; p < 16; p++) begin
      px = blk.block_col * 4 + p % 4;
      py = blk.block_row * 4 + p / 4;
      if (px >= wlim || py >= hlim) continue;
      if (have_held) queue_pixel(held);
      ci = blk.color_bits[32 + 2 * p +: 2];
      held.pixel_x = 12'(px);
      held.pixel_y = 12'(py);
      held.red     = 8'(pal[ci][0]);
      held.green   = 8'(pal[ci][1]);
      held.blue    = 8'(pal[ci][2]);
      held.alpha   = cur_setup.dxt5 ? alpha_level(a0, a1, blk.alpha_bits[16 + 3 * p +: 3])
                                    : 8'd255;
      held.last    = 1'b0;
      have_held    = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      queue_pixel(held);
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Drain pending pixels, let zero-pixel blocks clear the front end, then reprogram.
  task automatic apply_setup(input setup_t s);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    // Only bit 0 of the format write counts; fill the rest with noise.
    write_reg(CFG_FORMAT_MODE, {12'($urandom), s.dxt5});
    write_reg(CFG_IMAGE_WIDTH, s.width);
    write_reg(CFG_IMAGE_HEIGHT, s.height);
    write_reg(CFG_IDX_SPARE, 13'($urandom));
    cur_setup = s;
  endtask

  // Present one block and return at the edge that accepts it.
  task automatic offer_block(input in_item_t blk);
    in_data  = blk;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Step to the next falling edge and sometimes drop valid for a burst.
  task automatic sender_pause();
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none when quiet.
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        // Hold off long enough for the block's queue to fill and stall input.
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Check every pixel beat against the oldest pending pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("error: pixel x=%0d y=%0d arrived with nothing expected",
                   out_data.pixel_x, out_data.pixel_y);
        fail_cnt++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
            out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue || out_data.alpha !== want.alpha ||
            out_data.last !== want.last) begin
          if (fail_cnt < MAX_REPORTS) begin
            $display("mismatch: expected x=%0d y=%0d rgba=%h_%h_%h_%h last=%b",
                     want.pixel_x, want.pixel_y, want.red, want.green, want.blue,
                     want.alpha, want.last);
            $display("          got      x=%0d y=%0d rgba=%h_%h_%h_%h last=%b",
                     out_data.pixel_x, out_data.pixel_y, out_data.red, out_data.green,
                     out_data.blue, out_data.alpha, out_data.last);
          end
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run as a failure once cycle_cnt reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    block_row_t  row;
    in_item_t    blk;
    out_item_t   pix;
    setup_t      s;
    int unsigned lim, col_hi, row_hi;

    // Directed rows. Flat rows decode to one colour that is easy to read off:
    // zero and all-ones blocks, pure endpoints, the three-colour midpoint and
    // black, a four-colour two-thirds mix, the DXT5 alpha extremes. Together
    // the rows reach every colour and alpha code, both palette choices, partial
    // and full clipping, zero sizes and sizes beyond the largest image.
    block_tab = '{
      '{SET_DXT1_FULL, CHK_FLAT,  32'h0000_00FF, '{64'h0, 64'h0, 10'd0, 10'd0}},
      '{SET_DXT1_FULL, CHK_FLAT,  32'h0000_00FF, '{ONES, ONES, 10'd1023, 10'd1023}},
      '{SET_DXT1_FULL, CHK_FLAT,  32'hFFFF_FFFF,
        '{64'h0, 64'h0000_0000_0000_FFFF, 10'd5, 10'd7}},
      '{SET_DXT1_FULL, CHK_FLAT,  32'h7F7F_7FFF,
        '{64'h0, 64'hAAAA_AAAA_FFFF_0000, 10'd0, 10'd1023}},
      '{SET_DXT1_FULL, CHK_FLAT,  32'hAA00_00FF,
        '{64'h0, 64'hAAAA_AAAA_0000_F800, 10'd1023, 10'd0}},
      '{SET_DXT1_FULL, CHK_MODEL, 32'h0, '{ONES, 64'hE4E4_E4E4_001F_F800, 10'd3, 10'd4}},
      '{SET_DXT1_FULL, CHK_MODEL, 32'h0, '{64'h0, 64'h1B1B_1B1B_F800_07E0, 10'd9, 10'd2}},
      '{SET_DXT1_FULL, CHK_MODEL, 32'h0, '{64'h0, 64'hE4E4_E4E4_1234_1234, 10'd1, 10'd1}},
      '{SET_DXT5_FULL, CHK_FLAT,  32'h0000_0000, '{64'h0, 64'h0, 10'd2, 10'd2}},
      '{SET_DXT5_FULL, CHK_FLAT,  32'hFFFF_FFFF, '{ONES, ONES, 10'd512, 10'd511}},
      '{SET_DXT5_FULL, CHK_MODEL, 32'h0,
        '{ALPHA_DESC, 64'hE4E4_E4E4_07E0_F81F, 10'd6, 10'd6}},
      '{SET_DXT5_FULL, CHK_MODEL, 32'h0,
        '{ALPHA_ASC, 64'hE4E4_E4E4_07E0_F81F, 10'd7, 10'd6}},
      '{SET_DXT5_FULL, CHK_MODEL, 32'h0,
        '{64'h0123_4567_89AB_CDEF, 64'h1B1B_1B1B_FFFF_0000, 10'd8, 10'd8}},
      '{SET_DXT1_6X5,  CHK_MODEL, 32'h0, '{64'h0, 64'hE4E4_E4E4_001F_F800, 10'd1, 10'd1}},
      '{SET_DXT1_6X5,  CHK_MODEL, 32'h0, '{64'h0, 64'h1B1B_1B1B_F800_07E0, 10'd0, 10'd0}},
      '{SET_DXT1_6X5,  CHK_EMPTY, 32'h0, '{64'h0, 64'h1B1B_1B1B_F800_07E0, 10'd2, 10'd0}},
      '{SET_DXT5_1X1,  CHK_MODEL, 32'h0,
        '{ALPHA_ASC, 64'hE4E4_E4E4_07E0_F81F, 10'd0, 10'd0}},
      '{SET_DXT5_1X1,  CHK_EMPTY, 32'h0, '{ALPHA_ASC, ONES, 10'd0, 10'd1}},
      '{SET_NO_WIDTH,  CHK_EMPTY, 32'h0, '{64'h0, ONES, 10'd0, 10'd0}},
      '{SET_NO_HEIGHT, CHK_EMPTY, 32'h0, '{64'h0, ONES, 10'd5, 10'd5}},
      '{SET_DXT5_MAX,  CHK_FLAT,  32'hFFFF_FFFF, '{ONES, ONES, 10'd1023, 10'd1023}},
      '{SET_DXT1_4095, CHK_MODEL, 32'h0,
        '{64'h0, 64'h9C63_21E4_5A5A_A5A5, 10'd1023, 10'd1023}},
      '{SET_DXT1_4095, CHK_MODEL, 32'h0,
        '{64'h0, 64'h36D8_C94E_A5A5_5A5A, 10'd1023, 10'd0}},
      '{SET_DXT1_FULL, CHK_MODEL, 32'h0, '{ONES, 64'h0F0F_F0F0_8410_7BEF, 10'd100, 10'd200}}
    };

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = block_tab[i];
      if (row.setup != cur_setup) apply_setup(row.setup);
      offer_block(row.blk);
      case (row.chk)
        CHK_MODEL: decode_block(row.blk);
        CHK_FLAT: begin
          for (int p = 0; p < 16; p++) begin
            pix.pixel_x = {row.blk.block_col, 2'(p)};
            pix.pixel_y = {row.blk.block_row, 2'(p >> 2)};
            {pix.red, pix.green, pix.blue, pix.alpha} = row.rgba;
            pix.last = (p == 15);
            queue_pixel(pix);
          end
        end
        default: ;
      endcase
      sender_pause();
    end

    // Random phases, each under its own setup. Keep positions mostly inside
    // small images so clipping edges are hit often, with up to two block rows
    // and columns beyond them.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       s = SET_DXT1_FULL;
        1:       s = SET_DXT5_FULL;
        2:       s = '{1'b0, 13'($urandom_range(1, 40)), 13'($urandom_range(1, 40))};
        3:       s = '{1'b1, 13'($urandom_range(1, 40)), 13'($urandom_range(1, 40))};
        4:       s = '{1'b1, 13'd8191, 13'($urandom_range(1, 4096))};
        5:       s = '{1'($urandom), 13'($urandom), 13'($urandom_range(0, 64))};
        default: s = '{1'($urandom), 13'd4096, 13'd4096};
      endcase
      // Run the last phase with no idling on either side; leftover receiver
      // stalls run out during the drain.
      quiet = (ph == RAND_PHASES - 1);
      apply_setup(s);
      lim    = (s.width > MAX_DIM) ? MAX_DIM : s.width;
      col_hi = (lim / 4 + 1 > 1023) ? 1023 : lim / 4 + 1;
      lim    = (s.height > MAX_DIM) ? MAX_DIM : s.height;
      row_hi = (lim / 4 + 1 > 1023) ? 1023 : lim / 4 + 1;
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        blk.alpha_bits = {$urandom, $urandom};
        blk.color_bits = {$urandom, $urandom};
        // Equal endpoints select the three-colour palette in DXT1.
        if ($urandom_range(0, 7) == 0) blk.color_bits[31:16] = blk.color_bits[15:0];
        blk.block_col = 10'($urandom_range(0, col_hi));
        blk.block_row = 10'($urandom_range(0, row_hi));
        // Start the long output hold while blocks keep coming.
        if (ph == 1 && i == 4) hold_go = 1'b1;
        offer_block(blk);
        decode_block(blk);
        sender_pause();
      end
    end

    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/s3tc_pkg.sv
src/s3tc_front.sv
src/s3tc_queue.sv
src/s3tc_back.sv
src/s3tc_block_decoder.sv
sim/tb.sv
